// File: hdl/tmsf_pkg.sv
// Shared constants, command codes, controller states and RAM port types of the tile map span fill.
package tmsf_pkg;

  localparam int unsigned MAP_WIDTH  = 128;
  localparam int unsigned MAP_HEIGHT = 100;
  localparam int unsigned CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned IDX_W      = $clog2(MAP_WIDTH + 1);
  localparam int unsigned CNT_W      = $clog2(MAP_WIDTH + 1);
  localparam int unsigned PAIR_W     = 16;
  localparam int unsigned CELL_W     = 2 * PAIR_W;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_LEFT,
    ST_RIGHT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

// File: hdl/tmsf_cell_ram.sv
// Cell store of the tile map: one write port, one registered read port.
module tmsf_cell_ram (
  input  logic                          clk,
  input  tmsf_pkg::ram_wr_t             wr,
  input  tmsf_pkg::ram_rd_t             rd,
  output logic [tmsf_pkg::CELL_W-1:0]   rd_data
);
  import tmsf_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: hdl/tile_map_span_fill_core.sv
// Tile map cell store with set, read and horizontal background span fill commands.
//
// The map of MAP_WIDTH by MAP_HEIGHT cells sits in one single-port-write, single-port-read
// RAM with a registered read port; each word holds the foreground pair in the upper half
// and the background pair in the lower half. One command is worked at a time. A set or read
// first reads its cell; an out-of-range command skips the RAM. A fill reads the start cell,
// then walks left and right one cell per cycle, reading the next cell while the current one
// is compared and rewritten. A finished result waits in the output register while the next
// command is taken. Cells must be loaded by set commands before they are read or filled.
module tile_map_span_fill_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [6:0] col,
  input  logic [6:0] row,
  input  logic [7:0] brush_set,
  input  logic [7:0] brush_index,
  input  logic       to_foreground,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       status,
  output logic [7:0] cells_written,
  output logic [6:0] span_first,
  output logic [6:0] span_last,
  output logic [7:0] fore_set,
  output logic [7:0] fore_index,
  output logic [7:0] back_set,
  output logic [7:0] back_index
);
  import tmsf_pkg::*;

  state_t state, state_next;

  logic [1:0]        cmd_q, cmd_q_next;
  logic [IDX_W-1:0]  col_q, col_q_next;
  logic [ADDR_W-1:0] row_base, row_base_next;
  logic [PAIR_W-1:0] brush, brush_next;
  logic              fg, fg_next;
  logic [PAIR_W-1:0] target, target_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  first, first_next;
  logic [IDX_W-1:0]  last, last_next;
  logic              bad, bad_next;
  logic [CELL_W-1:0] cell_q, cell_q_next;

  ram_wr_t           wr;
  ram_rd_t           rd;
  logic [CELL_W-1:0] rd_data;

  logic              accept;
  logic              in_range;
  logic              load;
  logic [CELL_W-1:0] filled;
  logic              match;
  logic [IDX_W-1:0]  col_up;
  logic [IDX_W-1:0]  idx_up;

  tmsf_cell_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_range  = (32'(col) < MAP_WIDTH) && (32'(row) < MAP_HEIGHT);
  assign load      = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign filled    = {rd_data[CELL_W-1:PAIR_W], brush};
  assign match     = (rd_data[PAIR_W-1:0] == target);
  assign col_up    = col_q + IDX_W'(1);
  assign idx_up    = idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    col_q    <= col_q_next;
    row_base <= row_base_next;
    brush    <= brush_next;
    fg       <= fg_next;
    target   <= target_next;
    idx      <= idx_next;
    cnt      <= cnt_next;
    first    <= first_next;
    last     <= last_next;
    bad      <= bad_next;
    cell_q   <= cell_q_next;
  end

  always_comb begin
    state_next    = state;
    cmd_q_next    = cmd_q;
    col_q_next    = col_q;
    row_base_next = row_base;
    brush_next    = brush;
    fg_next       = fg;
    target_next   = target;
    idx_next      = idx;
    cnt_next      = cnt;
    first_next    = first;
    last_next     = last;
    bad_next      = bad;
    cell_q_next   = cell_q;
    wr            = '0;
    rd            = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_q_next    = command;
          col_q_next    = IDX_W'(col);
          row_base_next = ADDR_W'(32'(row) * MAP_WIDTH);
          brush_next    = {brush_set, brush_index};
          fg_next       = to_foreground;
          cnt_next      = '0;
          first_next    = '0;
          last_next     = '0;
          if (in_range) begin
            bad_next   = 1'b0;
            rd.en      = 1'b1;
            rd.addr    = ADDR_W'(32'(row) * MAP_WIDTH + 32'(col));
            state_next = ST_LOOK;
          end else begin
            bad_next    = 1'b1;
            cell_q_next = '0;
            state_next  = ST_DONE;
          end
        end
      end

      ST_LOOK: begin
        case (cmd_q)
          CMD_SET: begin
            wr.en       = 1'b1;
            wr.addr     = row_base + ADDR_W'(col_q);
            wr.data     = fg ? {brush, rd_data[PAIR_W-1:0]}
                             : {rd_data[CELL_W-1:PAIR_W], brush};
            cell_q_next = wr.data;
            cnt_next    = CNT_W'(1);
            state_next  = ST_DONE;
          end
          CMD_FILL: begin
            target_next = rd_data[PAIR_W-1:0];
            wr.en       = 1'b1;
            wr.addr     = row_base + ADDR_W'(col_q);
            wr.data     = filled;
            cell_q_next = filled;
            cnt_next    = CNT_W'(1);
            first_next  = col_q;
            last_next   = col_q;
            if (col_q != '0) begin
              rd.en      = 1'b1;
              rd.addr    = row_base + ADDR_W'(col_q - IDX_W'(1));
              idx_next   = col_q - IDX_W'(1);
              state_next = ST_LEFT;
            end else if (32'(col_up) < MAP_WIDTH) begin
              rd.en      = 1'b1;
              rd.addr    = row_base + ADDR_W'(col_up);
              idx_next   = col_up;
              state_next = ST_RIGHT;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: begin
            // read, and the unused code
            cell_q_next = rd_data;
            state_next  = ST_DONE;
          end
        endcase
      end

      ST_LEFT: begin
        if (match) begin
          wr.en      = 1'b1;
          wr.addr    = row_base + ADDR_W'(idx);
          wr.data    = filled;
          cnt_next   = cnt + CNT_W'(1);
          first_next = idx;
        end
        if (match && idx != '0) begin
          rd.en    = 1'b1;
          rd.addr  = row_base + ADDR_W'(idx - IDX_W'(1));
          idx_next = idx - IDX_W'(1);
        end else if (32'(col_up) < MAP_WIDTH) begin
          rd.en      = 1'b1;
          rd.addr    = row_base + ADDR_W'(col_up);
          idx_next   = col_up;
          state_next = ST_RIGHT;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_RIGHT: begin
        if (match) begin
          wr.en     = 1'b1;
          wr.addr   = row_base + ADDR_W'(idx);
          wr.data   = filled;
          cnt_next  = cnt + CNT_W'(1);
          last_next = idx;
          if (32'(idx_up) < MAP_WIDTH) begin
            rd.en    = 1'b1;
            rd.addr  = row_base + ADDR_W'(idx_up);
            idx_next = idx_up;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= bad;
      cells_written <= (32'(cnt) > 32'd255) ? 8'd255 : 8'(cnt);
      span_first    <= 7'(first);
      span_last     <= 7'(last);
      fore_set      <= cell_q[31:24];
      fore_index    <= cell_q[23:16];
      back_set      <= cell_q[15:8];
      back_index    <= cell_q[7:0];
    end
  end

endmodule

// File: tb/tile_map_span_fill_core_tb.sv
`timescale 1ns / 100ps
// Testbench for tile_map_span_fill_core: row loads, sets, reads and span fills checked per transfer.
module tile_map_span_fill_core_tb;
  import tmsf_pkg::*;

  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned RUN_LIMIT = 1_000_000;

  typedef struct {
    logic       status;
    logic [7:0] cells_written;
    logic [6:0] span_first;
    logic [6:0] span_last;
    logic [7:0] fore_set;
    logic [7:0] fore_index;
    logic [7:0] back_set;
    logic [7:0] back_index;
    bit         fore_known;
    bit         back_known;
  } map_reply_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [1:0] command = 2'd0;
  logic [6:0] col = 7'd0;
  logic [6:0] row = 7'd0;
  logic [7:0] brush_set = 8'd0;
  logic [7:0] brush_index = 8'd0;
  logic       to_foreground = 1'b0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       status;
  logic [7:0] cells_written;
  logic [6:0] span_first;
  logic [6:0] span_last;
  logic [7:0] fore_set;
  logic [7:0] fore_index;
  logic [7:0] back_set;
  logic [7:0] back_index;

  logic [15:0] fore_pair [CELL_COUNT];
  logic [15:0] back_pair [CELL_COUNT];
  bit          fore_written [CELL_COUNT];
  bit          back_written [CELL_COUNT];

  map_reply_t  replies_due [$];
  logic [15:0] palette [4] = '{16'h0000, 16'hFFFF, 16'h5AA5, 16'h8001};
  int          loaded_rows [4] = '{0, 45, 64, 99};

  int send_idle_pct = 31;
  int recv_idle_pct = 49;
  int hold_request = 0;
  int hold_left = 0;
  int failures = 0;
  int replies_checked = 0;
  int sets_done = 0;
  int fills_done = 0;
  int reads_done = 0;
  int rejects_done = 0;
  int widest_fill = 0;
  int unsigned cycle_count = 0;

  tile_map_span_fill_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .col          (col),
    .row          (row),
    .brush_set    (brush_set),
    .brush_index  (brush_index),
    .to_foreground(to_foreground),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .cells_written(cells_written),
    .span_first   (span_first),
    .span_last    (span_last),
    .fore_set     (fore_set),
    .fore_index   (fore_index),
    .back_set     (back_set),
    .back_index   (back_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cell store update and reply for one accepted command
  function automatic map_reply_t run_map_command(logic [1:0] cmd, logic [6:0] c, logic [6:0] r,
                                                 logic [15:0] brush, logic fg);
    map_reply_t rep;
    int base, a, i, n, lo, hi;
    logic [15:0] target;
    rep = '{default: '0};
    rep.fore_known = 1;
    rep.back_known = 1;
    n = 0;
    if (int'(r) >= int'(MAP_HEIGHT)) begin
      rep.status = 1'b1;
      rejects_done++;
      return rep;
    end
    base = int'(r) * int'(MAP_WIDTH);
    a = base + int'(c);
    if (cmd == CMD_SET) begin
      if (fg) begin
        fore_pair[a] = brush;
        fore_written[a] = 1;
      end else begin
        back_pair[a] = brush;
        back_written[a] = 1;
      end
      n = 1;
      sets_done++;
    end else if (cmd == CMD_FILL) begin
      target = back_pair[a];
      lo = int'(c);
      i = int'(c);
      while (i >= 0 && back_pair[base + i] == target) begin
        back_pair[base + i] = brush;
        n++;
        lo = i;
        i--;
      end
      hi = int'(c);
      i = int'(c) + 1;
      while (i < int'(MAP_WIDTH) && back_pair[base + i] == target) begin
        back_pair[base + i] = brush;
        n++;
        hi = i;
        i++;
      end
      rep.span_first = lo[6:0];
      rep.span_last = hi[6:0];
      fills_done++;
      if (n > widest_fill) widest_fill = n;
    end else begin
      reads_done++;
    end
    rep.cells_written = (n > 255) ? 8'd255 : n[7:0];
    {rep.fore_set, rep.fore_index} = fore_pair[a];
    {rep.back_set, rep.back_index} = back_pair[a];
    rep.fore_known = fore_written[a];
    rep.back_known = back_written[a];
    return rep;
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [6:0] c, logic [6:0] r,
                              logic [15:0] brush, logic fg);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    col <= c;
    row <= r;
    {brush_set, brush_index} <= brush;
    to_foreground <= fg;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    replies_due.push_back(run_map_command(cmd, c, r, brush, fg));
  endtask

  task automatic wait_replies_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    map_reply_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        failures++;
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        check_field("status", 8'(want.status), 8'(status));
        check_field("cells_written", want.cells_written, cells_written);
        check_field("span_first", 8'(want.span_first), 8'(span_first));
        check_field("span_last", 8'(want.span_last), 8'(span_last));
        if (want.fore_known) begin
          check_field("fore_set", want.fore_set, fore_set);
          check_field("fore_index", want.fore_index, fore_index);
        end
        if (want.back_known) begin
          check_field("back_set", want.back_set, back_set);
          check_field("back_index", want.back_index, back_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_rejected_coordinates();
    send_command(CMD_FILL, 7'd127, 7'd100, 16'hFFFF, 1'b1);
    send_command(CMD_SET, 7'd0, 7'd127, 16'h0000, 1'b0);
    send_command(CMD_READ, 7'd64, 7'd100, 16'hA5A5, 1'b0);
    send_command(CMD_SPARE, 7'd5, 7'd110, 16'h5A5A, 1'b1);
    wait_replies_drained();
  endtask

  // rows used by fills get both halves of every cell; two rows uniform, the rest in runs
  task automatic test_row_load();
    int r, c;
    logic [15:0] bg, fg_pair;
    for (int k = 0; k < 4; k++) begin
      r = loaded_rows[k];
      bg = (r == 99) ? palette[1] : palette[0];
      for (c = 0; c < int'(MAP_WIDTH); c++) begin
        if (r != 0 && r != 99 && $urandom_range(11) == 0) bg = palette[$urandom_range(3)];
        fg_pair = 16'($urandom);
        if ($urandom_range(1)) begin
          send_command(CMD_SET, c[6:0], r[6:0], bg, 1'b0);
          send_command(CMD_SET, c[6:0], r[6:0], fg_pair, 1'b1);
        end else begin
          send_command(CMD_SET, c[6:0], r[6:0], fg_pair, 1'b1);
          send_command(CMD_SET, c[6:0], r[6:0], bg, 1'b0);
        end
      end
    end
    wait_replies_drained();
  endtask

  task automatic test_directed_fills();
    send_command(CMD_READ, 7'd0, 7'd0, 16'h0000, 1'b0);
    send_command(CMD_SPARE, 7'd127, 7'd99, 16'hFFFF, 1'b1);
    send_command(CMD_SET, 7'd127, 7'd0, 16'hFFFF, 1'b1);
    send_command(CMD_SET, 7'd0, 7'd99, 16'h0000, 1'b1);
    // brush equal to the pair found: whole row walked anyway
    send_command(CMD_FILL, 7'd0, 7'd0, palette[0], 1'b0);
    send_command(CMD_FILL, 7'd127, 7'd0, palette[1], 1'b1);
    send_command(CMD_SET, 7'd64, 7'd0, palette[2], 1'b0);
    send_command(CMD_FILL, 7'd64, 7'd0, 16'h00FF, 1'b0);
    send_command(CMD_FILL, 7'd0, 7'd0, palette[3], 1'b1);
    send_command(CMD_FILL, 7'd127, 7'd0, palette[2], 1'b0);
    send_command(CMD_FILL, 7'd127, 7'd99, 16'hFF00, 1'b0);
    send_command(CMD_FILL, 7'd0, 7'd99, 16'h0000, 1'b1);
    send_command(CMD_FILL, 7'd63, 7'd45, 16'($urandom), 1'b0);
    send_command(CMD_READ, 7'd64, 7'd0, 16'h0000, 1'b0);
    send_command(CMD_SET, 7'd10, 7'd20, 16'hC33C, 1'b1);
    send_command(CMD_SET, 7'd10, 7'd20, 16'h3CC3, 1'b0);
    send_command(CMD_READ, 7'd10, 7'd20, 16'h0000, 1'b1);
    wait_replies_drained();
  endtask

  // result side held off long enough for the block to back up into its input
  task automatic test_output_backpressure();
    int r;
    hold_request = 400;
    for (int k = 0; k < 12; k++) begin
      r = loaded_rows[$urandom_range(3)];
      send_command((k % 3 == 0) ? CMD_FILL : CMD_READ, 7'($urandom_range(127)), r[6:0],
                   palette[$urandom_range(3)], 1'($urandom_range(1)));
    end
    wait_replies_drained();
  endtask

  task automatic test_random_traffic(int count);
    int pick, r, c, a;
    logic fg;
    logic [15:0] brush;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      fg = 1'($urandom_range(1));
      brush = 16'($urandom);
      r = loaded_rows[$urandom_range(3)];
      c = $urandom_range(127);
      if (pick < 8) begin
        send_command(2'($urandom_range(3)), c[6:0], 7'($urandom_range(127, 100)), brush, fg);
      end else if (pick < 35) begin
        if ($urandom_range(3) == 0) r = $urandom_range(MAP_HEIGHT - 1);
        if (!fg && $urandom_range(3) != 0) brush = palette[$urandom_range(3)];
        send_command(CMD_SET, c[6:0], r[6:0], brush, fg);
      end else if (pick < 75) begin
        if ($urandom_range(3) != 0) brush = palette[$urandom_range(3)];
        send_command(CMD_FILL, c[6:0], r[6:0], brush, fg);
      end else begin
        if ($urandom_range(9) < 3) begin
          pick = $urandom_range(MAP_HEIGHT - 1);
          a = pick * int'(MAP_WIDTH) + c;
          if (fore_written[a] && back_written[a]) r = pick;
        end
        send_command($urandom_range(1) ? CMD_READ : CMD_SPARE, c[6:0], r[6:0], brush, fg);
      end
    end
    wait_replies_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rejected_coordinates();
    test_row_load();
    test_directed_fills();
    test_output_backpressure();
    test_random_traffic(20);
    send_idle_pct = 49;
    recv_idle_pct = 31;
    test_random_traffic(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(20);
    repeat (150) @(posedge clk);
    $display("checked %0d results: %0d sets, %0d fills, %0d reads, %0d rejected",
             replies_checked, sets_done, fills_done, reads_done, rejects_done);
    $display("widest fill span %0d cells, %0d mismatches", widest_fill, failures);
    if (failures == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
